// ----- hdl/ascii85_stream_decoder_top_macros.svh -----
// Assertion macros for the ascii85 stream decoder port checker.
// Used by a85_port_checker.sv; expects clk and rst in scope.
`ifndef ASCII85_STREAM_DECODER_TOP_MACROS_SVH
`define ASCII85_STREAM_DECODER_TOP_MACROS_SVH

// Check a property outside of reset.
`define A85_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property that also covers the reset cycles.
`define A85_CHECK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/a85_pkg.sv -----
// Shared types, character codes and helpers for the ascii85 stream decoder.
// No dependencies; imported by the front, queue, back and top modules.
package a85_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharFf    = 8'h0c;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [7:0] CharZ     = 8'h7a;
  localparam logic [7:0] CharTilde = 8'h7e;

  localparam logic [2:0] GroupDigits = 3'd5;
  localparam logic [2:0] GroupBytes  = 3'd4;

  // One unit of work for the back end: nbytes bytes from value (after padding
  // with pad 'u' digits), or a single flag-only result when nbytes is zero.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  pad;
    logic [2:0]  nbytes;
    logic        term;
    logic        err;
  } a85_cmd_t;

  // 85^pad; padding with pad 'u' digits maps g to (g + 1) * 85^pad - 1.
  function automatic logic [19:0] pad_scale(input logic [1:0] pad);
    logic [19:0] s;
    case (pad)
      2'd1:    s = 20'd85;
      2'd2:    s = 20'd7225;
      2'd3:    s = 20'd614125;
      default: s = 20'd1;
    endcase
    return s;
  endfunction

  // g * 85 modulo 2^32 as shifts and adds.
  function automatic logic [31:0] times85(input logic [31:0] g);
    logic [31:0] r;
    r = (g << 6) + (g << 4) + (g << 2) + g;
    return r;
  endfunction

  // Command that closes a stream holding dc pending digits in g.
  function automatic a85_cmd_t finish_cmd(input logic [31:0] g, input logic [2:0] dc);
    a85_cmd_t c;
    c = '0;
    c.term = 1'b1;
    if (dc == 3'd1) begin
      c.err = 1'b1;
    end else if (dc > 3'd1) begin
      c.value  = g;
      c.pad    = 2'(GroupDigits - dc);
      c.nbytes = dc - 3'd1;
    end
    return c;
  endfunction

endpackage

// ----- hdl/ascii85_stream_decoder_top.sv -----
// Ascii85 stream decoder: one character in per beat, decoded bytes out.
// Channels: char (char_byte, end_of_data) in, byte (data_byte, is_data,
// stream_end, error_flag) out, both valid/ready.
// Whitespace and '%' comments are dropped; five digits give four bytes, a
// 'z' gives four zero bytes, '~' or end_of_data closes the stream and pads
// any partial group. A stream that ends with nothing to flush gives one
// beat with is_data low and stream_end high; an illegal character or a lone
// tail digit gives one beat with error_flag and stream_end high.
// Path: a character's first result passes the queue, the pad multiply register
// and the serializer register after the character's accept.
// Throughput: one character per cycle while results keep pace; the output
// moves one result beat per cycle while byte_ready is high, so a group or
// 'z' fills four beats and the command queue (QUEUE_DEPTH entries) absorbs it.
// Stalls: when byte_ready is low the serializer holds its beat, the queue
// fills, and char_ready drops once it is full.
// Reset: synchronous, clears group state, the queue and both back stages.
// Depends on a85_pkg, a85_front, a85_queue, a85_back.
module ascii85_stream_decoder_top import a85_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       end_of_data,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] data_byte,
  output logic       is_data,
  output logic       stream_end,
  output logic       error_flag
);

  logic     push, queue_full, pop, queue_empty;
  a85_cmd_t push_cmd, pop_cmd;

  a85_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_byte   (char_byte),
    .end_of_data (end_of_data),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  a85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  a85_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop         (pop),
    .cmd         (pop_cmd),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .is_data     (is_data),
    .stream_end  (stream_end),
    .error_flag  (error_flag)
  );

endmodule

// ----- hdl/a85_front.sv -----
// Front end: accepts characters, tracks group and comment state, and issues
// one command per character that yields results. Depends on a85_pkg.
module a85_front import a85_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       end_of_data,
  input  logic       queue_full,
  output logic       push,
  output a85_cmd_t   cmd
);

  logic [31:0] group_value, group_value_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        in_comment, in_comment_next;

  logic        accept;
  logic        is_space, is_digit, is_eol;
  logic [31:0] digit_group;
  logic [2:0]  digit_inc;
  logic        emit;

  assign char_ready = !queue_full;
  assign accept     = char_valid && char_ready;
  assign push       = accept && emit;

  assign is_eol   = (char_byte == CharCr) || (char_byte == CharLf);
  assign is_space = (char_byte == CharNul) || (char_byte == CharTab) || is_eol ||
                    (char_byte == CharFf) || (char_byte == CharSpace);
  assign is_digit = (char_byte >= CharBang) && (char_byte <= CharU);

  assign digit_group = times85(group_value) + {24'b0, char_byte - CharBang};
  assign digit_inc   = digit_count + 3'd1;

  always_comb begin
    emit             = 1'b0;
    cmd              = '0;
    group_value_next = group_value;
    digit_count_next = digit_count;
    in_comment_next  = in_comment;
    if (char_byte == CharTilde) begin
      emit             = 1'b1;
      cmd              = finish_cmd(group_value, digit_count);
      group_value_next = '0;
      digit_count_next = '0;
      in_comment_next  = 1'b0;
    end else if (in_comment || is_space || char_byte == CharPct) begin
      if (in_comment && is_eol) begin
        in_comment_next = 1'b0;
      end else if (!in_comment && char_byte == CharPct) begin
        in_comment_next = 1'b1;
      end
      if (end_of_data) begin
        emit             = 1'b1;
        cmd              = finish_cmd(group_value, digit_count);
        group_value_next = '0;
        digit_count_next = '0;
        in_comment_next  = 1'b0;
      end
    end else if (char_byte == CharZ && digit_count == 3'd0) begin
      emit       = 1'b1;
      cmd.nbytes = GroupBytes;
      cmd.term   = end_of_data;
    end else if (!is_digit) begin
      emit             = 1'b1;
      cmd.term         = 1'b1;
      cmd.err          = 1'b1;
      group_value_next = '0;
      digit_count_next = '0;
    end else if (digit_inc == GroupDigits) begin
      emit             = 1'b1;
      cmd.value        = digit_group;
      cmd.nbytes       = GroupBytes;
      cmd.term         = end_of_data;
      group_value_next = '0;
      digit_count_next = '0;
    end else if (end_of_data) begin
      emit             = 1'b1;
      cmd              = finish_cmd(digit_group, digit_inc);
      group_value_next = '0;
      digit_count_next = '0;
    end else begin
      group_value_next = digit_group;
      digit_count_next = digit_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_value <= '0;
      digit_count <= '0;
      in_comment  <= 1'b0;
    end else if (accept) begin
      group_value <= group_value_next;
      digit_count <= digit_count_next;
      in_comment  <= in_comment_next;
    end
  end

endmodule

// ----- hdl/a85_queue.sv -----
// Command queue between the front and back ends: a small register FIFO.
// Depends on a85_pkg for the command type.
module a85_queue import a85_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  a85_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output a85_cmd_t pop_cmd,
  output logic     empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  a85_cmd_t        entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ----- hdl/a85_back.sv -----
// Back end: pads tail groups with one constant multiply, then serializes
// each command into result beats. Depends on a85_pkg.
module a85_back import a85_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  output logic       pop,
  input  a85_cmd_t   cmd,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] data_byte,
  output logic       is_data,
  output logic       stream_end,
  output logic       error_flag
);

  // pad stage
  logic        m_valid;
  logic [31:0] m_value;
  logic [2:0]  m_nbytes;
  logic        m_term, m_err;

  // serializer stage
  logic        s_valid;
  logic [31:0] s_value;
  logic [2:0]  s_left;
  logic        s_isd, s_term, s_err;

  logic        s_last, s_free, s_load, m_free;
  logic [31:0] inc_value, padded;
  logic [51:0] product;

  assign inc_value = cmd.value + 32'd1;
  assign product   = {20'b0, inc_value} * {32'b0, pad_scale(cmd.pad)};
  assign padded    = product[31:0] - 32'd1;

  assign s_last = (s_left == 3'd1);
  assign s_free = !s_valid || (byte_ready && s_last);
  assign s_load = m_valid && s_free;
  assign m_free = !m_valid || s_load;
  assign pop    = !queue_empty && m_free;

  always_ff @(posedge clk) begin
    if (pop) begin
      m_value  <= (cmd.pad != 2'd0) ? padded : cmd.value;
      m_nbytes <= cmd.nbytes;
      m_term   <= cmd.term;
      m_err    <= cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_value <= m_value;
      s_left  <= (m_nbytes == 3'd0) ? 3'd1 : m_nbytes;
      s_isd   <= (m_nbytes != 3'd0);
      s_term  <= m_term;
      s_err   <= m_err;
    end else if (s_valid && byte_ready && !s_last) begin
      // advance to the next byte of the group
      s_value <= s_value << 8;
      s_left  <= s_left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_free) begin
      s_valid <= s_load;
    end
  end

  assign byte_valid = s_valid;
  assign data_byte  = s_isd ? s_value[31:24] : 8'd0;
  assign is_data    = s_isd;
  assign stream_end = s_term && s_last;
  assign error_flag = s_err;

endmodule

// ----- hdl/a85_port_checker.sv -----
// Port-level checks for the ascii85 stream decoder, bound to the top level.
// Depends on ascii85_stream_decoder_top_macros.svh.
`include "ascii85_stream_decoder_top_macros.svh"

module a85_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_ready,
  input logic       byte_valid,
  input logic       byte_ready,
  input logic [7:0] data_byte,
  input logic       is_data,
  input logic       stream_end,
  input logic       error_flag
);

  // reset empties the result path and opens the input
  `A85_CHECK_RST(reset_clears_chk, rst |=> !byte_valid && char_ready, "reset did not clear")

  // a stalled result beat holds
  `A85_CHECK(beat_hold_chk, !$past(rst) && $past(byte_valid) && !$past(byte_ready) |-> byte_valid && $stable(data_byte) && $stable(is_data) && $stable(stream_end) && $stable(error_flag), "stalled beat changed")

  // errors only appear as flag-only beats that close the stream
  `A85_CHECK(error_shape_chk, byte_valid && error_flag |-> stream_end && !is_data, "bad error beat")

  // flag-only beats carry a zero byte
  `A85_CHECK(flag_zero_chk, byte_valid && !is_data |-> data_byte == 8'd0 && stream_end, "bad flag beat")

endmodule

bind ascii85_stream_decoder_top a85_port_checker u_port_checker (.*);
